// File: rtl/sse_pkg.sv
`timescale 1ns / 1ps
// Shared constants, action codes and the result type of the sparse set engine.
package sse_pkg;

  localparam int ID_SPACE = 4096;
  localparam int ID_W     = $clog2(ID_SPACE);
  localparam int CNT_W    = ID_W + 1;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_TEST   = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  typedef struct packed {
    logic             was_member;
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  dense_value;
    logic             position_valid;
  } result_t;

endpackage

// File: rtl/sse_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
module sse_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/sse_core.sv
`timescale 1ns / 1ps
// Sparse set core: membership, slot and dense memories with the request sequencer.
module sse_core
  import sse_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  logic [1:0]      action,
  input  logic [ID_W-1:0] value,
  input  logic [ID_W-1:0] position,
  input  logic            hold,
  output logic            done,
  output result_t         result
);

  localparam logic [1:0] CLEAR_S = 2'd0;
  localparam logic [1:0] IDLE_S  = 2'd1;
  localparam logic [1:0] EXEC_S  = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] member_count;
  logic [CNT_W-1:0] member_count_next;
  logic [ID_W-1:0]  clr_addr;
  logic [1:0]       act_q;
  logic [ID_W-1:0]  value_q;
  logic [ID_W-1:0]  pos_q;

  logic             accept;
  logic [CNT_W-1:0] last_count;
  logic [ID_W-1:0]  dense_raddr;

  logic             mem_member;
  logic [ID_W-1:0]  slot_rd;
  logic [ID_W-1:0]  dense_rd;

  logic             bit_we;
  logic [ID_W-1:0]  bit_waddr;
  logic             bit_wdata;
  logic             slot_we;
  logic [ID_W-1:0]  slot_waddr;
  logic [ID_W-1:0]  slot_wdata;
  logic             dense_we;
  logic [ID_W-1:0]  dense_waddr;
  logic [ID_W-1:0]  dense_wdata;

  logic             do_insert;
  logic             do_remove;
  logic             pos_ok;

  assign req_stall   = (state != IDLE_S);
  assign accept      = req_valid && !req_stall;
  assign last_count  = member_count - CNT_W'(1);
  assign dense_raddr = (action == ACT_READ) ? position : last_count[ID_W-1:0];

  sse_ram #(.WIDTH(1), .DEPTH(ID_SPACE)) u_bits (
    .clk   (clk),
    .we    (bit_we),
    .waddr (bit_waddr),
    .wdata (bit_wdata),
    .re    (accept),
    .raddr (value),
    .rdata (mem_member)
  );

  sse_ram #(.WIDTH(ID_W), .DEPTH(ID_SPACE)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (accept),
    .raddr (value),
    .rdata (slot_rd)
  );

  sse_ram #(.WIDTH(ID_W), .DEPTH(ID_SPACE)) u_dense (
    .clk   (clk),
    .we    (dense_we),
    .waddr (dense_waddr),
    .wdata (dense_wdata),
    .re    (accept),
    .raddr (dense_raddr),
    .rdata (dense_rd)
  );

  always_comb begin
    state_next        = state;
    member_count_next = member_count;
    done              = 1'b0;
    do_insert         = 1'b0;
    do_remove         = 1'b0;
    pos_ok            = ({1'b0, pos_q} < member_count);
    bit_we            = 1'b0;
    bit_waddr         = value_q;
    bit_wdata         = 1'b0;
    slot_we           = 1'b0;
    slot_waddr        = value_q;
    slot_wdata        = member_count[ID_W-1:0];
    dense_we          = 1'b0;
    dense_waddr       = member_count[ID_W-1:0];
    dense_wdata       = value_q;
    result            = '0;

    unique case (state)
      CLEAR_S: begin
        bit_we    = 1'b1;
        bit_waddr = clr_addr;
        if (clr_addr == ID_W'(ID_SPACE - 1)) begin
          state_next = IDLE_S;
        end
      end
      IDLE_S: begin
        if (accept) begin
          state_next = EXEC_S;
        end
      end
      EXEC_S: begin
        if (!hold) begin
          done       = 1'b1;
          state_next = IDLE_S;
          case (act_q)
            ACT_INSERT: begin
              do_insert = !mem_member && (member_count < CNT_W'(ID_SPACE));
            end
            ACT_REMOVE: begin
              do_remove = mem_member;
            end
            default: begin
            end
          endcase

          if (do_insert) begin
            bit_we            = 1'b1;
            bit_wdata         = 1'b1;
            slot_we           = 1'b1;
            dense_we          = 1'b1;
            member_count_next = member_count + CNT_W'(1);
          end

          if (do_remove) begin
            // The last dense entry moves into the freed slot.
            bit_we            = 1'b1;
            bit_wdata         = 1'b0;
            dense_we          = 1'b1;
            dense_waddr       = slot_rd;
            dense_wdata       = dense_rd;
            slot_we           = (dense_rd != value_q);
            slot_waddr        = dense_rd;
            slot_wdata        = slot_rd;
            member_count_next = last_count;
          end

          result.count = member_count_next;
          if (act_q == ACT_READ) begin
            result.position_valid = pos_ok;
            result.dense_value    = pos_ok ? dense_rd : '0;
          end else begin
            result.was_member = mem_member;
          end
        end
      end
      default: begin
        state_next = IDLE_S;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= CLEAR_S;
      member_count <= '0;
      clr_addr     <= '0;
    end else begin
      state        <= state_next;
      member_count <= member_count_next;
      if (state == CLEAR_S) begin
        clr_addr <= clr_addr + ID_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q   <= action;
      value_q <= value;
      pos_q   <= position;
    end
  end

endmodule

// File: rtl/sparse_set_engine_unit.sv
`timescale 1ns / 1ps
// Top level of the sparse set engine: request intake, core and result register.
//
//   Channel   Handshake               Payload
//   -------   ---------------------   -------------------------------------------
//   in        in_valid / in_stall     action, value, position
//   out       out_valid / out_stall   was_member, count, dense_value, position_valid
//
// The accepting edge reads the membership, slot and dense memories; in the
// write-back state, once not held, they are written back and the result
// register is loaded. The write-back needs the registered read data, so a
// new request is taken only after the last one is written back.
// After reset a clearing pass over all ID_SPACE (4096) addresses zeroes the
// membership memory; in_stall is high throughout it.
// A stalled result holds the core in its write-back cycle, so no request
// is lost; a new request is taken while a finished result waits.
module sparse_set_engine_unit
  import sse_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       action,
  input  logic [ID_W-1:0]  value,
  input  logic [ID_W-1:0]  position,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             was_member,
  output logic [CNT_W-1:0] count,
  output logic [ID_W-1:0]  dense_value,
  output logic             position_valid
);

  logic    hold;
  logic    done;
  result_t result;
  result_t result_q;

  // The core may finish only when the result register is free or draining.
  assign hold = out_valid && out_stall;

  sse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid),
    .req_stall (in_stall),
    .action    (action),
    .value     (value),
    .position  (position),
    .hold      (hold),
    .done      (done),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload register: loaded only when a request completes.
  always_ff @(posedge clk) begin
    if (done) begin
      result_q <= result;
    end
  end

  assign was_member     = result_q.was_member;
  assign count          = result_q.count;
  assign dense_value    = result_q.dense_value;
  assign position_valid = result_q.position_valid;

endmodule
